// ===== rtl/sfdd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdd_pkg
// Shared types and constants for the sensor frame deframer and decoder.
// ----------------------------------------------------------------------------
package sfdd_pkg;

   localparam int PAYLOAD_LEN = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_BYTE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_OFFSET = 2'd3;

   localparam logic [7:0]  HEADER_RESET      = 8'h3A;
   localparam logic [7:0]  TAIL_RESET        = 8'hFF;
   localparam logic [15:0] LIMIT_RESET       = 16'd1600;
   localparam logic [7:0]  OFFSET_RESET      = 8'd60;
   localparam logic [7:0]  MID_ANGLE_RESET   = 8'd45;
   localparam logic [7:0]  ANGLE_FOLD_THRESH = 8'd90;
   localparam logic [7:0]  ANGLE_FOLD_SUB    = 8'd180;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  tail_byte;
      logic [15:0] distance_limit;
      logic [7:0]  distance_offset;
   } cfg_type;

   typedef struct packed {
      logic                        emit;
      logic                        awaiting_tail;
      logic [PAYLOAD_LEN-1:0][7:0] payload;
   } frame_type;

   typedef struct packed {
      logic signed [8:0] target_distance;
      logic signed [7:0] target_angle;
      logic [15:0]       start_distance;
      logic [7:0]        mid_angle;
      logic [7:0]        end_angle;
      logic [7:0]        start_angle;
   } result_type;

endpackage

// ===== rtl/sfdd_csr.sv =====
// ----------------------------------------------------------------------------
// sfdd_csr
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sfdd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfdd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfdd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sfdd_pkg::cfg_type                 cfg
);
   import sfdd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_BYTE:     cfg_in.header_byte     = csr_wdata[7:0];
            CSR_TAIL_BYTE:       cfg_in.tail_byte       = csr_wdata[7:0];
            CSR_DISTANCE_LIMIT:  cfg_in.distance_limit  = csr_wdata[15:0];
            CSR_DISTANCE_OFFSET: cfg_in.distance_offset = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte     <= HEADER_RESET;
         cfg_ff.tail_byte       <= TAIL_RESET;
         cfg_ff.distance_limit  <= LIMIT_RESET;
         cfg_ff.distance_offset <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sfdd_parser.sv =====
// ----------------------------------------------------------------------------
// sfdd_parser
// Byte-wise frame parser: hunts for the header, collects six payload bytes
// and checks the tail.
// ----------------------------------------------------------------------------
module sfdd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic [7:0]        rx_byte,
   input  sfdd_pkg::cfg_type cfg,
   output sfdd_pkg::frame_type frame
);
   import sfdd_pkg::*;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TAIL    = 2'd2;

   localparam logic [2:0] COUNT_FIRST = 3'd1;
   localparam logic [2:0] COUNT_LAST  = 3'(PAYLOAD_LEN);

   logic [1:0] phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   logic [PAYLOAD_LEN-1:0][7:0] store_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (beat) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               if (count_ff >= COUNT_LAST) begin
                  count_in = COUNT_FIRST;
                  phase_in = PH_TAIL;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_TAIL: phase_in = PH_HUNT;
            default: phase_in = (rx_byte == cfg.header_byte) ? PH_PAYLOAD : PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= COUNT_FIRST;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         if (beat && phase_ff == PH_PAYLOAD && count_ff == 3'(i + 1)) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   assign frame.awaiting_tail = (phase_ff == PH_TAIL);
   assign frame.emit          = beat && (phase_ff == PH_TAIL) && (rx_byte == cfg.tail_byte);
   assign frame.payload       = store_ff;

endmodule

// ===== rtl/sfdd_decode.sv =====
// ----------------------------------------------------------------------------
// sfdd_decode
// Decodes a closed frame into the result register and keeps the last good
// distance and mid angle.
// ----------------------------------------------------------------------------
module sfdd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  sfdd_pkg::frame_type   frame,
   input  sfdd_pkg::cfg_type     cfg,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output sfdd_pkg::result_type  result,
   output logic                  held
);
   import sfdd_pkg::*;

   logic        valid_ff, valid_in;
   result_type  result_ff, result_in;
   logic        held_ff, held_in;
   logic [15:0] last_dist_ff, last_dist_in;
   logic [7:0]  last_mid_ff, last_mid_in;

   logic [8:0]  angle_sum;
   logic [15:0] raw_dist;
   logic        over;

   always_comb begin
      angle_sum = {1'b0, frame.payload[0]} + {1'b0, frame.payload[1]};
      raw_dist  = {frame.payload[2], frame.payload[3]};
      over      = raw_dist > cfg.distance_limit;

      result_in.start_angle    = frame.payload[0];
      result_in.end_angle      = frame.payload[1];
      result_in.mid_angle      = over ? last_mid_ff  : angle_sum[8:1];
      result_in.start_distance = over ? last_dist_ff : raw_dist;
      result_in.target_angle   = (frame.payload[4] > ANGLE_FOLD_THRESH)
                                 ? signed'(frame.payload[4] - ANGLE_FOLD_SUB)
                                 : signed'(frame.payload[4]);
      result_in.target_distance = signed'({1'b0, frame.payload[5]}
                                          - {1'b0, cfg.distance_offset});
      held_in = over;

      valid_in     = frame.emit ? 1'b1 : (valid_ff && !rsp_tready);
      last_dist_in = frame.emit ? result_in.start_distance : last_dist_ff;
      last_mid_in  = frame.emit ? result_in.mid_angle      : last_mid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         last_dist_ff <= '0;
         last_mid_ff  <= MID_ANGLE_RESET;
      end else begin
         valid_ff     <= valid_in;
         last_dist_ff <= last_dist_in;
         last_mid_ff  <= last_mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.emit) begin
         result_ff <= result_in;
         held_ff   <= held_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign result     = result_ff;
   assign held       = held_ff;

endmodule

// ===== rtl/sensor_frame_deframer_decoder.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_deframer_decoder
// Output: a frame result appears in the cycle after its tail beat is taken.
// Throughput: one byte per cycle; the tail beat waits only while a previous
// result is still held in the single output register.
// Reset: synchronous, active high; control and CSR regs reset, parser hunts.
// Deframes header/six payload/tail byte frames and decodes the payload.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] start_angle, [15:8] end_angle, [23:16] mid_angle,
   // [39:24] start_distance, [47:40] target_angle, [56:48] target_distance,
   // [63:57] zero
   output logic [sfdd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,  // [0] distance_held
   input  logic                            csr_we,
   input  logic [sfdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfdd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sfdd_pkg::*;

   cfg_type    cfg;
   frame_type  frame;
   result_type result;
   logic       beat;

   assign req_tready = !rsp_tvalid || rsp_tready || !frame.awaiting_tail;
   assign beat       = req_tvalid && req_tready;

   sfdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfdd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .rx_byte (req_tdata),
      .cfg     (cfg),
      .frame   (frame)
   );

   sfdd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .cfg        (cfg),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .result     (result),
      .held       (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, result};

`ifndef NO_ASSERTIONS
   a_no_emit_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !frame.emit)
      else $error("frame closed while result register still occupied");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      frame.emit |=> rsp_tvalid)
      else $error("closed frame produced no result beat");

   a_tail_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (frame.awaiting_tail && rsp_tvalid))
      else $error("input stalled outside the tail position");
`endif

endmodule
